/* rtl/core/i2p_pkg.sv */
// Package for the infix to postfix converter: types, constants and decode functions.
`default_nettype none

package i2p_pkg;

  // Stack sizing.
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned CAPACITY    = (STACK_DEPTH < STORE_DEPTH) ? STACK_DEPTH : STORE_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  // ASCII codes of the operator characters.
  localparam logic [7:0] CHAR_ADD   = 8'h2B;
  localparam logic [7:0] CHAR_SUB   = 8'h2D;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_MOD   = 8'h25;
  localparam logic [7:0] CHAR_POW   = 8'h5E;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  // Operator codes as stored on the stack.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_POW   = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_e;

  // Error codes of a result beat.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_e;

  // Sequencer states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } state_e;

  // Input beat.
  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
  } in_item_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic [1:0] error;
    logic       last;
  } out_item_t;

  // Result of classifying one input character.
  typedef struct packed {
    logic found;
    op_e  op;
  } op_lookup_t;

  // Map a character to its operator code, if it is one.
  function automatic op_lookup_t op_decode(logic [7:0] sym);
    op_lookup_t res;
    res.found = 1'b1;
    res.op    = OP_ADD;
    case (sym)
      CHAR_ADD:   res.op = OP_ADD;
      CHAR_SUB:   res.op = OP_SUB;
      CHAR_MUL:   res.op = OP_MUL;
      CHAR_DIV:   res.op = OP_DIV;
      CHAR_MOD:   res.op = OP_MOD;
      CHAR_POW:   res.op = OP_POW;
      CHAR_OPEN:  res.op = OP_OPEN;
      CHAR_CLOSE: res.op = OP_CLOSE;
      default:    res.found = 1'b0;
    endcase
    return res;
  endfunction

  // Map an operator code back to its character.
  function automatic logic [7:0] op_char(op_e op);
    logic [7:0] c;
    case (op)
      OP_ADD:   c = CHAR_ADD;
      OP_SUB:   c = CHAR_SUB;
      OP_MUL:   c = CHAR_MUL;
      OP_DIV:   c = CHAR_DIV;
      OP_MOD:   c = CHAR_MOD;
      OP_POW:   c = CHAR_POW;
      OP_OPEN:  c = CHAR_OPEN;
      OP_CLOSE: c = CHAR_CLOSE;
      default:  c = CHAR_ADD;
    endcase
    return c;
  endfunction

  // Precedence level of an arithmetic operator.
  function automatic logic [1:0] op_level(op_e op);
    logic [1:0] lvl;
    case (op)
      OP_ADD, OP_SUB:         lvl = 2'd0;
      OP_MUL, OP_DIV, OP_MOD: lvl = 2'd1;
      OP_POW:                 lvl = 2'd2;
      default:                lvl = 2'd0;
    endcase
    return lvl;
  endfunction

  // True when the stack top must be popped before pushing the new operator.
  // A parenthesis on the stack never yields.
  function automatic logic op_yields(op_e top, op_e op);
    return (top != OP_OPEN) && (top != OP_CLOSE) && (op_level(top) >= op_level(op));
  endfunction

endpackage

`default_nettype wire

/* rtl/core/i2p_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module i2p_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/infix_to_postfix_converter_unit.sv */
// Top level of the infix to postfix converter (shunting-yard operator stack).
//
// Input channel: in_valid_i / in_stall_o carry one beat per infix character,
// or an end command that flushes the operator stack. Output channel:
// out_valid_o / out_stall_i carry postfix characters and status beats; the
// last beat caused by an input beat has its last flag set. An input beat
// that causes nothing (a push, or a flush of an empty stack) gives no beat.
// An accepted input beat is registered in the item register, and its first
// result beat is then registered in the output register. The sequencer does
// one stack pop per cycle while the output slot is free; the pop loop on the
// stack RAM sets the pace of the block. A new input beat is taken in the
// cycle after the previous one is finished.
// The stack lives in a RAM with a registered read; the top entry is held in
// a register and the RAM read port always fetches the entry below it.
// Reset empties the stack and the output register; no clearing pass is run.
// When the receiver stalls, the output register holds its beat and the work
// sequencer waits; no result is lost.
`default_nettype none

module infix_to_postfix_converter_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire i2p_pkg::in_item_t     in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output i2p_pkg::out_item_t         out_data_o
);

  import i2p_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       top_q, top_d;
  in_item_t         item_q, item_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [2:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [2:0]        ram_rdata;

  logic             accept;
  logic             step;
  logic             emit;
  logic             done;
  out_item_t        res;
  op_lookup_t       dec;
  op_e              top_op;
  op_e              below_op;
  logic             has_top;
  logic             has_below;
  logic             full;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] raddr_sum;

  // Operator stack storage.
  i2p_ram #(
    .WIDTH (3),
    .DEPTH (STORE_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Stack view: the RAM data is always the entry just below the top.
  assign dec       = op_decode(item_q.symbol);
  assign top_op    = op_e'(top_q);
  assign below_op  = op_e'(ram_rdata);
  assign has_top   = (count_q != '0);
  assign has_below = (count_q > CNT_W'(1));
  assign full      = (count_q >= CNT_W'(CAPACITY));
  assign count_dec = count_q - CNT_W'(1);

  // Read address tracks the next count so the entry under the top is ready.
  assign raddr_sum = count_d - CNT_W'(2);
  assign ram_raddr = raddr_sum[ADDR_W-1:0];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = (state_q == ST_WORK) && (!out_valid_q || !out_stall_i);

  // Sequencer: one stack step per cycle while the output slot is free.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_d     = top_q;
    item_d    = item_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = dec.op;
    emit      = 1'b0;
    done      = 1'b0;
    res       = '0;

    if (accept) begin
      item_d  = in_data_i;
      state_d = ST_WORK;
    end

    if (step) begin
      if (item_q.command) begin
        // Flush: pop and emit every entry, parentheses included.
        if (has_top) begin
          emit           = 1'b1;
          res.out_symbol = op_char(top_op);
          res.has_symbol = 1'b1;
          res.last       = !has_below;
          count_d        = count_dec;
          top_d          = ram_rdata;
          done           = !has_below;
        end else begin
          done = 1'b1;
        end
      end else if (!dec.found) begin
        // Operand or unknown character passes straight out.
        emit           = 1'b1;
        res.out_symbol = item_q.symbol;
        res.has_symbol = 1'b1;
        res.last       = 1'b1;
        done           = 1'b1;
      end else if (dec.op == OP_OPEN) begin
        // Open parenthesis is pushed, or flagged when the stack is full.
        if (full) begin
          emit      = 1'b1;
          res.error = ERR_OVERFLOW;
          res.last  = 1'b1;
        end else begin
          ram_we  = 1'b1;
          top_d   = dec.op;
          count_d = count_q + CNT_W'(1);
        end
        done = 1'b1;
      end else if (dec.op == OP_CLOSE) begin
        // Close parenthesis pops down to the matching open one.
        if (!has_top) begin
          emit      = 1'b1;
          res.error = ERR_UNMATCHED;
          res.last  = 1'b1;
          done      = 1'b1;
        end else if (top_op == OP_OPEN) begin
          count_d = count_dec;
          top_d   = ram_rdata;
          done    = 1'b1;
        end else begin
          emit           = 1'b1;
          res.out_symbol = op_char(top_op);
          res.has_symbol = 1'b1;
          res.last       = !has_below || (below_op == OP_OPEN);
          res.error      = has_below ? ERR_NONE : ERR_UNMATCHED;
          count_d        = count_dec;
          top_d          = ram_rdata;
          done           = !has_below;
        end
      end else begin
        // Arithmetic operator: pop while the top yields, then push.
        if (has_top && op_yields(top_op, dec.op)) begin
          emit           = 1'b1;
          res.out_symbol = op_char(top_op);
          res.has_symbol = 1'b1;
          if (has_below && op_yields(below_op, dec.op)) begin
            count_d = count_dec;
            top_d   = ram_rdata;
          end else begin
            // Final pop: the operator replaces the popped top in place.
            res.last  = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = count_dec[ADDR_W-1:0];
            top_d     = dec.op;
            done      = 1'b1;
          end
        end else if (full) begin
          emit      = 1'b1;
          res.error = ERR_OVERFLOW;
          res.last  = 1'b1;
          done      = 1'b1;
        end else begin
          ram_we  = 1'b1;
          top_d   = dec.op;
          count_d = count_q + CNT_W'(1);
          done    = 1'b1;
        end
      end

      if (done) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Output register loads a beat when one is produced.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* dv/i2p_postfix_checker.sv */
// Checker for the infix to postfix converter: predicts every output beat and compares it.
module i2p_postfix_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  i2p_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  i2p_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 beat_count_o,
  output int                 flag_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2p_pkg::*;

  // Shadow copy of the operator stack.
  op_e         op_stack [STORE_DEPTH];
  int unsigned op_depth;

  // Postfix beats that the block still owes, oldest first.
  out_item_t   postfix_due [$];
  out_item_t   want;

  // Operator code of a character; returns 0 for operands.
  function automatic bit char_to_op(input logic [7:0] c, output op_e op);
    op = OP_ADD;
    case (c)
      CHAR_ADD:   op = OP_ADD;
      CHAR_SUB:   op = OP_SUB;
      CHAR_MUL:   op = OP_MUL;
      CHAR_DIV:   op = OP_DIV;
      CHAR_MOD:   op = OP_MOD;
      CHAR_POW:   op = OP_POW;
      CHAR_OPEN:  op = OP_OPEN;
      CHAR_CLOSE: op = OP_CLOSE;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Character that a popped stack entry is written out as.
  function automatic logic [7:0] stack_char(op_e op);
    case (op)
      OP_ADD:  return CHAR_ADD;
      OP_SUB:  return CHAR_SUB;
      OP_MUL:  return CHAR_MUL;
      OP_DIV:  return CHAR_DIV;
      OP_MOD:  return CHAR_MOD;
      OP_POW:  return CHAR_POW;
      OP_OPEN: return CHAR_OPEN;
      default: return CHAR_CLOSE;
    endcase
  endfunction

  // Binding strength; a parenthesis on the stack never gives way.
  function automatic int binding(op_e op);
    case (op)
      OP_ADD, OP_SUB:         return 0;
      OP_MUL, OP_DIV, OP_MOD: return 1;
      OP_POW:                 return 2;
      default:                return -1;
    endcase
  endfunction

  function automatic out_item_t make_beat(logic [7:0] sym, logic has, err_e err);
    out_item_t b;
    b.out_symbol = sym;
    b.has_symbol = has;
    b.error      = err;
    b.last       = 1'b0;
    return b;
  endfunction

  // Run one input beat through the shunting-yard rules and queue what it releases.
  function automatic void convert_beat(in_item_t beat);
    out_item_t burst [$];
    op_e       op;
    bit        is_op;
    bit        matched;
    is_op   = char_to_op(beat.symbol, op);
    matched = 1'b0;
    if (beat.command) begin
      while (op_depth > 0) begin
        burst.push_back(make_beat(stack_char(op_stack[op_depth-1]), 1'b1, ERR_NONE));
        op_depth--;
      end
    end else if (!is_op) begin
      burst.push_back(make_beat(beat.symbol, 1'b1, ERR_NONE));
    end else if (op == OP_CLOSE) begin
      // Pop down to the matching open parenthesis, which is dropped.
      while (op_depth > 0 && !matched) begin
        if (op_stack[op_depth-1] == OP_OPEN) begin
          matched = 1'b1;
        end else begin
          burst.push_back(make_beat(stack_char(op_stack[op_depth-1]), 1'b1, ERR_NONE));
        end
        op_depth--;
      end
      if (!matched) begin
        if (burst.size() == 0) begin
          burst.push_back(make_beat(8'h00, 1'b0, ERR_UNMATCHED));
        end else begin
          burst[burst.size()-1].error = ERR_UNMATCHED;
        end
      end
    end else begin
      // Arithmetic operators first pop everything that binds at least as tightly.
      if (op != OP_OPEN) begin
        while (op_depth > 0 && binding(op_stack[op_depth-1]) >= binding(op)) begin
          burst.push_back(make_beat(stack_char(op_stack[op_depth-1]), 1'b1, ERR_NONE));
          op_depth--;
        end
      end
      if (op_depth >= CAPACITY) begin
        burst.push_back(make_beat(8'h00, 1'b0, ERR_OVERFLOW));
      end else begin
        op_stack[op_depth] = op;
        op_depth++;
      end
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
    end
    foreach (burst[i]) begin
      postfix_due.push_back(burst[i]);
    end
  endfunction

  // Compare output beats first, then predict from the input beat of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_depth = 0;
      postfix_due.delete();
      fail_count_o = 0;
      pending_o = 0;
      beat_count_o = 0;
      flag_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        beat_count_o++;
        if (out_data_i.error != ERR_NONE) begin
          flag_count_o++;
        end
        if (postfix_due.size() == 0) begin
          $error("unexpected output beat: symbol %02h has %0b error %0d last %0b",
                 out_data_i.out_symbol, out_data_i.has_symbol, out_data_i.error,
                 out_data_i.last);
          fail_count_o++;
        end else begin
          want = postfix_due.pop_front();
          if (out_data_i.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %02h, actual %02h", want.out_symbol,
                   out_data_i.out_symbol);
            fail_count_o++;
          end
          if (out_data_i.has_symbol !== want.has_symbol) begin
            $error("has_symbol: expected %0b, actual %0b", want.has_symbol,
                   out_data_i.has_symbol);
            fail_count_o++;
          end
          if (out_data_i.error !== want.error) begin
            $error("error: expected %0d, actual %0d", want.error, out_data_i.error);
            fail_count_o++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_data_i.last);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        convert_beat(in_data_i);
      end
      pending_o = postfix_due.size();
    end
  end

endmodule

/* dv/tb_infix_to_postfix_converter_unit.sv */
// Testbench top for the infix to postfix converter: stimulus, back-pressure and verdict.
module tb_infix_to_postfix_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import i2p_pkg::*;

  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int        fail_count;
  int        pending;
  int        beat_count;
  int        flag_count;
  int        items_sent;
  int        round;
  int        random_start;
  bit        idle_on;
  bit        hold_req;
  bit        hold_taken;

  infix_to_postfix_converter_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  i2p_postfix_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beat_count_o (beat_count),
    .flag_count_o (flag_count)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #3_000_000;
    $display("infix_to_postfix_converter_unit test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_taken = 1'b1;
      end else begin
        out_stall = idle_on && ($urandom_range(99) < 18);
      end
    end
  end

  function automatic bit is_special(logic [7:0] c);
    return c == CHAR_ADD || c == CHAR_SUB || c == CHAR_MUL || c == CHAR_DIV ||
           c == CHAR_MOD || c == CHAR_POW || c == CHAR_OPEN || c == CHAR_CLOSE;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(5))
      0:       return CHAR_ADD;
      1:       return CHAR_SUB;
      2:       return CHAR_MUL;
      3:       return CHAR_DIV;
      4:       return CHAR_MOD;
      default: return CHAR_POW;
    endcase
  endfunction

  // Mostly letters, sometimes any byte that is not an operator character.
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(99) < 60) begin
      return 8'h61 + 8'($urandom_range(25));
    end
    do c = 8'($urandom_range(255)); while (is_special(c));
    return c;
  endfunction

  // Offer one beat at a falling edge and hold it until it is taken.
  task automatic send_beat(input logic cmd, input logic [7:0] sym);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.command = cmd;
    in_data.symbol = sym;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(1'b0, s[i]);
    end
  endtask

  task automatic send_end();
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // Sender pause until every predicted beat has come out.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A well-formed expression with random operands, operators and nesting.
  task automatic send_expression(input int terms);
    int opens;
    opens = 0;
    for (int t = 0; t < terms; t++) begin
      while (opens < 8 && $urandom_range(99) < 25) begin
        send_beat(1'b0, CHAR_OPEN);
        opens++;
      end
      send_beat(1'b0, pick_operand());
      while (opens > 0 && $urandom_range(99) < 35) begin
        send_beat(1'b0, CHAR_CLOSE);
        opens--;
      end
      if (t != terms - 1) begin
        send_beat(1'b0, pick_operator());
      end
    end
    // Now and then leave an open parenthesis for the flush to emit.
    while (opens > 0 && $urandom_range(99) < 85) begin
      send_beat(1'b0, CHAR_CLOSE);
      opens--;
    end
    send_end();
  endtask

  // Broken input: stray parentheses, operators, bytes and end commands.
  task automatic send_noise(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_end();
      end else if (r < 30) begin
        send_beat(1'b0, ($urandom_range(1) != 0) ? CHAR_OPEN : CHAR_CLOSE);
      end else if (r < 55) begin
        send_beat(1'b0, pick_operator());
      end else begin
        send_beat(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  // Main stimulus.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    round = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Extreme bytes, flush and close parenthesis on an empty stack.
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b0, CHAR_CLOSE);
    // Every operator, nesting and left-associative power.
    send_text("(a+b)*c^d^e-f/g%h");
    send_end();
    // Unmatched close parenthesis after some operators.
    send_text("a+b*c)");
    // Leftover open parenthesis is emitted by the flush.
    send_text("(x");
    send_end();
    drain();

    // Fill the stack to the top, then overflow it with both kinds of push.
    for (int i = 0; i < int'(CAPACITY) / 2; i++) begin
      send_beat(1'b0, CHAR_OPEN);
      send_beat(1'b0, CHAR_ADD);
    end
    send_beat(1'b0, CHAR_OPEN);
    send_beat(1'b0, CHAR_MUL);
    send_beat(1'b0, CHAR_CLOSE);
    send_end();
    drain();

    // Random part: mostly well-formed expressions, some noise.
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      round++;
      idle_on = !(round >= 4 && round < 10);
      if (round == 3) begin
        // Receiver holds off while the sender keeps pushing operands.
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
          send_beat(1'b0, pick_operand());
        end
      end
      if (round == 11) begin
        drain();
      end
      if ($urandom_range(99) < 80) begin
        send_expression($urandom_range(1, 8));
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d input beats: operands, all operators, nesting, flushes, overflow.",
             items_sent);
    $display("Checked %0d output beats, %0d of them carrying an error flag.",
             beat_count, flag_count);
    if (fail_count == 0) begin
      $display("infix_to_postfix_converter_unit test passed");
    end else begin
      $display("infix_to_postfix_converter_unit test failed");
    end
    $finish;
  end

endmodule
